>>> rtl/core/xs1024s_pkg.sv
// Shared types and constants for the xorshift1024* generator.
`timescale 1ns / 1ps

package xs1024s_pkg;

  localparam int WORD_W    = 64;
  localparam int NUM_WORDS = 16;
  localparam int ADDR_W    = 4;
  localparam int BITS_W    = 10;

  localparam logic [WORD_W-1:0] MULTIPLIER     = 64'd1181783497276652981;
  localparam logic [WORD_W-1:0] SEED_LAST_WORD = 64'd123456789123456789;
  localparam logic [31:0]       MULT_LO        = MULTIPLIER[31:0];
  localparam logic [31:0]       MULT_HI        = MULTIPLIER[63:32];

  localparam int SHIFT_A = 31;
  localparam int SHIFT_B = 11;
  localparam int SHIFT_C = 30;

  localparam logic [WORD_W-1:0] JUMP_POLY [NUM_WORDS] = '{
    64'h84242f96eca9c41d, 64'ha3c65b8776f96855,
    64'h5b34a39f070b5837, 64'h4489affce4f31a1e,
    64'h2ffeeb0a48316f40, 64'hdc2d9891fe68c022,
    64'h3659132bb12fea70, 64'haac17d8efa43cab8,
    64'hc4cb815590989b13, 64'h5ee975283d71c93b,
    64'h691548c86c1bd540, 64'h7910c41d10a1e6a5,
    64'h0b5fc64563b3e2a8, 64'h047f7684e9fc949d,
    64'hb99181f2d8f685ca, 64'h284600e3f30e38c3
  };

  typedef enum logic [1:0] {
    REQ_SEED = 2'd0,
    REQ_GEN  = 2'd1,
    REQ_JUMP = 2'd2,
    REQ_NONE = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_MUL,
    ST_JBIT,
    ST_JSWEEP,
    ST_JWB,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_P0,
    MS_P1,
    MS_P2,
    MS_SUM
  } mul_step_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  // Value of a state word that has not been written since reset.
  function automatic logic [WORD_W-1:0] reset_word(input logic [ADDR_W-1:0] addr);
    reset_word = (&addr) ? SEED_LAST_WORD : '0;
  endfunction

endpackage

>>> rtl/core/xorshift1024_star_generator.sv
// Top level of the xorshift1024* generator: request sequencer and result register.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   req_type, word_index, seed_word
// out      output     out_valid / out_stall result_kind, random_value
//
// Steps: a seed write or an unused kind goes straight to the result register; a
// generate does a state read, an update/write-back, a product in the 32x32
// multiplier, and a load of the result register. A jump tests each polynomial
// bit, sweeps the state words into the accumulator through the state memory read
// port for a set bit, advances the state, and finally writes the accumulator back.
// Reset clears the pointer, the FSM, the output valid and the memory valid
// bits; unwritten state words read as their reset seed, so no clearing pass.
// One request is in work at a time; in_stall is high while it runs. A result
// waiting on out_stall does not block the next input transaction.
`timescale 1ns / 1ps

module xorshift1024_star_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [xs1024s_pkg::ADDR_W-1:0] word_index,
  input  logic [xs1024s_pkg::WORD_W-1:0] seed_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     result_kind,
  output logic [xs1024s_pkg::WORD_W-1:0] random_value
);
  import xs1024s_pkg::*;

  ctrl_state_t       state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [BITS_W-1:0] bit_cnt, bit_cnt_next;
  logic [ADDR_W:0]   sweep_idx, sweep_idx_next;   // 0..16
  logic [1:0]        kind_q, kind_q_next;
  logic [WORD_W-1:0] value_q, value_q_next;

  logic [ADDR_W-1:0] st_ra, st_rb, acc_ra;
  mem_wr_t           st_wr, acc_wr;
  logic              acc_clear;
  logic [WORD_W-1:0] st_rd_a, st_rd_b, acc_rd;

  logic              mul_start, mul_done;
  logic [WORD_W-1:0] mul_product;
  logic              load_out;

  logic [WORD_W-1:0] w1_mix, adv_word;
  logic [ADDR_W:0]   idx_m1;
  logic              poly_bit;

  // one generator step: w0 at ptr (port a), w1 at ptr+1 (port b)
  assign w1_mix   = st_rd_b ^ (st_rd_b << SHIFT_A);
  assign adv_word = w1_mix ^ st_rd_a ^ (w1_mix >> SHIFT_B) ^ (st_rd_a >> SHIFT_C);
  assign idx_m1   = sweep_idx - 1'b1;
  assign poly_bit = JUMP_POLY[bit_cnt[9:6]][bit_cnt[5:0]];

  assign in_stall = (state != ST_IDLE);

  xs1024s_state_mem u_state_mem (
    .clk       (clk),
    .rst       (rst),
    .rd_addr_a (st_ra),
    .rd_addr_b (st_rb),
    .wr        (st_wr),
    .rd_data_a (st_rd_a),
    .rd_data_b (st_rd_b)
  );

  xs1024s_acc_mem u_acc_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (acc_clear),
    .rd_addr (acc_ra),
    .wr      (acc_wr),
    .rd_data (acc_rd)
  );

  xs1024s_scramble u_scramble (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (adv_word),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      bit_cnt   <= '0;
      sweep_idx <= '0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      bit_cnt   <= bit_cnt_next;
      sweep_idx <= sweep_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q  <= kind_q_next;
    value_q <= value_q_next;
  end

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    bit_cnt_next   = bit_cnt;
    sweep_idx_next = sweep_idx;
    kind_q_next    = kind_q;
    value_q_next   = value_q;
    // advance reads are issued by default; extra reads are harmless
    st_ra          = ptr;
    st_rb          = ptr + 1'b1;
    st_wr          = '0;
    acc_ra         = sweep_idx[ADDR_W-1:0];
    acc_wr         = '0;
    acc_clear      = 1'b0;
    mul_start      = 1'b0;
    load_out       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          kind_q_next  = req_type;
          value_q_next = '0;
          unique case (req_type)
            REQ_SEED: begin
              st_wr      = '{en: 1'b1, addr: word_index, data: seed_word};
              state_next = ST_DONE;
            end
            REQ_GEN:  state_next = ST_ADV;
            REQ_JUMP: begin
              acc_clear    = 1'b1;
              bit_cnt_next = '0;
              state_next   = ST_JBIT;
            end
            default:  state_next = ST_DONE;
          endcase
        end
      end

      ST_ADV: begin
        st_wr    = '{en: 1'b1, addr: ptr + 1'b1, data: adv_word};
        ptr_next = ptr + 1'b1;
        if (kind_q == REQ_GEN) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end else begin
          bit_cnt_next = bit_cnt + 1'b1;   // wraps to zero after the last bit
          if (&bit_cnt) begin
            sweep_idx_next = '0;
            state_next     = ST_JWB;
          end else begin
            state_next = ST_JBIT;
          end
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          value_q_next = mul_product;
          state_next   = ST_DONE;
        end
      end

      ST_JBIT: begin
        if (poly_bit) begin
          acc_ra         = '0;
          sweep_idx_next = 5'd1;
          state_next     = ST_JSWEEP;
        end else begin
          state_next = ST_ADV;
        end
      end

      // acc[j] ^= state[ptr+j], read of j+1 overlaps write of j
      ST_JSWEEP: begin
        acc_wr = '{en: 1'b1, addr: idx_m1[ADDR_W-1:0], data: acc_rd ^ st_rd_a};
        if (sweep_idx[ADDR_W]) begin
          state_next = ST_ADV;
        end else begin
          st_ra          = ptr + sweep_idx[ADDR_W-1:0];
          acc_ra         = sweep_idx[ADDR_W-1:0];
          sweep_idx_next = sweep_idx + 1'b1;
        end
      end

      // state[ptr+j] = acc[j]
      ST_JWB: begin
        if (sweep_idx != '0) begin
          st_wr = '{en: 1'b1, addr: ptr + idx_m1[ADDR_W-1:0], data: acc_rd};
        end
        if (sweep_idx[ADDR_W]) begin
          state_next = ST_DONE;
        end else begin
          acc_ra         = sweep_idx[ADDR_W-1:0];
          sweep_idx_next = sweep_idx + 1'b1;
        end
      end

      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_kind  <= kind_q;
      random_value <= value_q;
    end
  end

endmodule

>>> rtl/core/xs1024s_state_mem.sv
// State word memory: 16 x 64, two registered read ports, one write port.
`timescale 1ns / 1ps

module xs1024s_state_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [xs1024s_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [xs1024s_pkg::ADDR_W-1:0] rd_addr_b,
  input  xs1024s_pkg::mem_wr_t       wr,
  output logic [xs1024s_pkg::WORD_W-1:0] rd_data_a,
  output logic [xs1024s_pkg::WORD_W-1:0] rd_data_b
);
  import xs1024s_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] written;

  // unwritten entries read as their reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= written[rd_addr_a] ? mem[rd_addr_a] : reset_word(rd_addr_a);
    rd_data_b <= written[rd_addr_b] ? mem[rd_addr_b] : reset_word(rd_addr_b);
  end

endmodule

>>> rtl/core/xs1024s_acc_mem.sv
// Jump accumulator memory: 16 x 64, one registered read port, clear by valid bits.
`timescale 1ns / 1ps

module xs1024s_acc_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [xs1024s_pkg::ADDR_W-1:0] rd_addr,
  input  xs1024s_pkg::mem_wr_t       wr,
  output logic [xs1024s_pkg::WORD_W-1:0] rd_data
);
  import xs1024s_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

>>> rtl/core/xs1024s_scramble.sv
// Output scrambler: 64 x constant multiply, low 64 bits, one 32x32 multiplier over 4 steps.
`timescale 1ns / 1ps

module xs1024s_scramble (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [xs1024s_pkg::WORD_W-1:0] operand,
  output logic                           done,
  output logic [xs1024s_pkg::WORD_W-1:0] product
);
  import xs1024s_pkg::*;

  mul_step_t         step;
  logic [WORD_W-1:0] opnd;
  logic [WORD_W-1:0] mul_q;
  logic [WORD_W-1:0] sum;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [WORD_W-1:0] mul_full;

  // lo*lo, then the two cross terms into the upper half
  assign mul_a    = (step == MS_P1) ? opnd[63:32] : opnd[31:0];
  assign mul_b    = (step == MS_P2) ? MULT_HI : MULT_LO;
  assign mul_full = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= MS_IDLE;
      done <= 1'b0;
    end else begin
      done <= (step == MS_SUM);
      unique case (step)
        MS_IDLE: if (start) step <= MS_P0;
        MS_P0:   step <= MS_P1;
        MS_P1:   step <= MS_P2;
        MS_P2:   step <= MS_SUM;
        MS_SUM:  step <= MS_IDLE;
        default: step <= MS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
    end
    mul_q <= mul_full;
    case (step)
      MS_P1:   sum <= mul_q;
      MS_P2:   sum[63:32] <= sum[63:32] + mul_q[31:0];
      MS_SUM:  product <= {sum[63:32] + mul_q[31:0], sum[31:0]};
      default: ;
    endcase
  end

endmodule
